/* hdl/arwd_pkg.sv */
// Package for the addressed register write decoder: state and result types,
// register indexes, reset values and the fixed target length table.
// No dependencies.
`timescale 1ns / 1ps

package arwd_pkg;

    // Field widths
    localparam int ByteW  = 8;
    localparam int CfgIdxW = 2;

    // Configuration register indexes
    localparam logic [CfgIdxW-1:0] CfgDotIndexAddr = 2'd0;
    localparam logic [CfgIdxW-1:0] CfgDotsTarget   = 2'd1;
    localparam logic [CfgIdxW-1:0] CfgDotsLength   = 2'd2;

    // Configuration reset values
    localparam logic [ByteW-1:0] RstDotIndexAddr = 8'd34;
    localparam logic [ByteW-1:0] RstDotsTarget   = 8'd33;
    localparam logic [ByteW-1:0] RstDotsLength   = 8'd243;

    // Fixed table
    localparam logic [ByteW-1:0] ArrayLen      = 8'd8;
    localparam logic [ByteW-1:0] LastFixedTgt  = 8'd37;

    typedef struct packed {
        logic [ByteW-1:0] dot_index_address;
        logic [ByteW-1:0] dots_target;
        logic [ByteW-1:0] dots_length;
    } t_cfg;

    typedef struct packed {
        logic [ByteW-1:0] current_target;
        logic [ByteW-1:0] write_position;
        logic             index_received;
    } t_state;

    typedef struct packed {
        logic [ByteW-1:0] write_byte;
        logic [ByteW-1:0] write_offset;
        logic [ByteW-1:0] write_target;
    } t_result;

    // Length of a fixed-table target, 0 when the target is unknown
    function automatic logic [ByteW-1:0] fixed_length(input logic [ByteW-1:0] tgt);
        logic [ByteW-1:0] len;
        len = '0;
        if (tgt == 8'd2 || tgt == 8'd3 || tgt == 8'd35) begin
            len = ArrayLen;
        end else if (tgt <= LastFixedTgt && tgt != 8'd33 && tgt != 8'd34) begin
            len = 8'd1;
        end
        return len;
    endfunction

endpackage

/* hdl/arwd_decode.sv */
// Word decoder: turns one received word and the current write state into
// the next state and at most one write. Uses arwd_pkg.
`timescale 1ns / 1ps

module arwd_decode (
    input  logic                    i_is_address,
    input  logic [arwd_pkg::ByteW-1:0] i_rx_byte,
    input  arwd_pkg::t_cfg          i_cfg,
    input  arwd_pkg::t_state        i_state,
    output arwd_pkg::t_state        o_state,
    output logic                    o_res_valid,
    output arwd_pkg::t_result       o_res
);

    logic [arwd_pkg::ByteW-1:0] len;

    // Length of the current target: dots array takes precedence over the table
    always_comb begin
        if (i_state.current_target == i_cfg.dots_target) begin
            len = i_cfg.dots_length;
        end else begin
            len = arwd_pkg::fixed_length(i_state.current_target);
        end
    end

    // Decide the write and advance the state
    always_comb begin
        o_state     = i_state;
        o_res_valid = 1'b0;
        o_res.write_target = i_state.current_target;
        o_res.write_offset = i_state.write_position;
        o_res.write_byte   = i_rx_byte;

        if (i_is_address) begin
            // Select a new target and rewind
            o_state.current_target = i_rx_byte;
            o_state.write_position = '0;
        end else if (i_state.current_target == i_cfg.dot_index_address) begin
            if (!i_state.index_received) begin
                // First byte is the dot index
                o_state.write_position = i_rx_byte;
                o_state.index_received = 1'b1;
            end else begin
                o_state.index_received = 1'b0;
                o_res.write_target     = i_cfg.dots_target;
                o_res_valid            = (i_state.write_position < i_cfg.dots_length);
            end
        end else if (len == 8'd1) begin
            // Single register: overwrite in place
            o_res.write_offset = '0;
            o_res_valid        = 1'b1;
        end else if (len != '0 && i_state.write_position < len) begin
            // Array fill at successive offsets, drop once full
            o_res_valid            = 1'b1;
            o_state.write_position = i_state.write_position + 8'd1;
        end
    end

endmodule

/* hdl/addressed_register_write_decoder_unit.sv */
// Addressed register write decoder, top level: configuration registers,
// write state, result register with skid stage. Uses arwd_pkg, arwd_decode.
`timescale 1ns / 1ps

// Usage
//   Slave stream: one received 9-bit word per request; tuser carries the
//   ninth (address) bit, tdata the eight data bits.
//   Master stream: one write request (target, offset, byte) for each data
//   word that lands in a known target; address words and dropped bytes give
//   nothing.
//   Configuration channel: index 0 dot index address, 1 dots target,
//   2 dots length; always ready, write only while the streams are idle.
// Write path and throughput
//   A write is registered in the result or, on a stall, the skid stage. One word
//   is accepted every cycle while the skid stage is empty; the decode is a single
//   compare and increment path from the state registers into the result register.
// Reset
//   i_rst_n low clears the write state and the result stages and loads the
//   register defaults (34, 33, 243).
// Stall
//   While the receiver holds tready low, one further write is parked in the
//   skid stage; o_s_tready then drops until the result register drains.
module addressed_register_write_decoder_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Slave stream
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // [7:0] rx_byte
    input  logic        i_s_tuser,   // [0] is_address
    // Master stream
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [23:0] o_m_tdata,   // [7:0] write_target, [15:8] write_offset,
                                     // [23:16] write_byte
    // Configuration write channel
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [arwd_pkg::CfgIdxW-1:0] i_cfg_index,
    input  logic [arwd_pkg::ByteW-1:0]   i_cfg_data
);

    arwd_pkg::t_cfg    r_cfg;
    arwd_pkg::t_state  r_state;
    arwd_pkg::t_state  n_state;
    arwd_pkg::t_result n_res;
    logic              n_res_valid;

    arwd_pkg::t_result r_out;
    logic              r_out_valid;
    arwd_pkg::t_result r_skid;
    logic              r_skid_valid;

    logic s_accept;
    logic out_free;

    assign o_cfg_ready = 1'b1;
    assign o_s_tready  = !r_skid_valid;
    assign s_accept    = i_s_tvalid && o_s_tready;
    assign out_free    = !r_out_valid || i_m_tready;

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out;

    // Hold configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.dot_index_address <= arwd_pkg::RstDotIndexAddr;
            r_cfg.dots_target       <= arwd_pkg::RstDotsTarget;
            r_cfg.dots_length       <= arwd_pkg::RstDotsLength;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                arwd_pkg::CfgDotIndexAddr: r_cfg.dot_index_address <= i_cfg_data;
                arwd_pkg::CfgDotsTarget:   r_cfg.dots_target       <= i_cfg_data;
                arwd_pkg::CfgDotsLength:   r_cfg.dots_length       <= i_cfg_data;
                default: ;
            endcase
        end
    end

    arwd_decode u_decode (
        .i_is_address (i_s_tuser),
        .i_rx_byte    (i_s_tdata),
        .i_cfg        (r_cfg),
        .i_state      (r_state),
        .o_state      (n_state),
        .o_res_valid  (n_res_valid),
        .o_res        (n_res)
    );

    // Advance write state on each accepted word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else if (s_accept) begin
            r_state <= n_state;
        end
    end

    // Result register and skid stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (out_free) begin
                if (r_skid_valid) begin
                    r_out_valid  <= 1'b1;
                    r_skid_valid <= 1'b0;
                end else begin
                    r_out_valid <= s_accept && n_res_valid;
                end
            end else if (s_accept && n_res_valid) begin
                r_skid_valid <= 1'b1;
            end
        end
    end

    // Payload moves without reset
    always_ff @(posedge i_clk) begin
        if (out_free) begin
            if (r_skid_valid) begin
                r_out <= r_skid;
            end else if (s_accept && n_res_valid) begin
                r_out <= n_res;
            end
        end else if (s_accept && n_res_valid) begin
            r_skid <= n_res;
        end
    end

endmodule

/* verif/tb_addressed_register_write_decoder_unit.sv */
// Self-checking bench for the addressed register write decoder: a clocked driver
// and monitor around the top level, with an inline predictor of the write decode.
// Depends on arwd_pkg and addressed_register_write_decoder_unit.
`timescale 1ns / 1ps

module tb_addressed_register_write_decoder_unit;

    // Targets with a fixed meaning in the target table
    localparam logic [7:0] TgtArrayA = 8'd2;
    localparam logic [7:0] TgtArrayB = 8'd3;
    localparam logic [7:0] TgtArrayC = 8'd35;
    localparam logic [7:0] TgtHoleA  = 8'd33;
    localparam logic [7:0] TgtHoleB  = 8'd34;

    localparam int HoldoffAt     = 300;   // words taken before the long receiver stall
    localparam int HoldoffCycles = 80;
    localparam int MaxShown      = 10;
    localparam int BurstWords    = 130;   // data words queued per traffic phase

    typedef struct packed {
        logic       addr;
        logic [7:0] rx;
    } t_rx_word;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_s_tvalid = 1'b0;
    logic        o_s_tready;
    logic [7:0]  i_s_tdata = '0;
    logic        i_s_tuser = 1'b0;
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b0;
    logic [23:0] o_m_tdata;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [arwd_pkg::CfgIdxW-1:0] i_cfg_index = '0;
    logic [arwd_pkg::ByteW-1:0]   i_cfg_data = '0;

    // Predictor copy of the registers and the write state
    logic [7:0] cfg_dot_addr = arwd_pkg::RstDotIndexAddr;
    logic [7:0] cfg_dots_tgt = arwd_pkg::RstDotsTarget;
    logic [7:0] cfg_dots_len = arwd_pkg::RstDotsLength;
    logic [7:0] cur_tgt  = '0;
    logic [7:0] wr_pos   = '0;
    logic       idx_seen = 1'b0;

    t_rx_word          rx_words[$];
    arwd_pkg::t_result due_writes[$];

    int  n_words_taken = 0;
    int  n_writes_seen = 0;
    int  n_faults      = 0;
    int  n_settings    = 1;
    bit  calm          = 1'b0;

    int  gap_left      = 0;
    int  stall_left    = 0;
    int  holdoff_left  = 0;
    int  ready_seen    = 0;
    bit  holdoff_done  = 1'b0;

    addressed_register_write_decoder_unit DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),    // [7:0] rx_byte
        .i_s_tuser   (i_s_tuser),    // [0] is_address
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),    // [7:0] target, [15:8] offset, [23:16] byte
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        i_clk = 1'b1;
        #2;
        i_clk = 1'b0;
        #2;
    end

    // Advance the decode state by one word; return 1 when it yields a write
    function automatic bit predict_write(input logic is_addr, input logic [7:0] rx,
                                         output arwd_pkg::t_result w);
        logic [7:0] len;
        w = '0;
        if (is_addr) begin
            cur_tgt = rx;
            wr_pos  = '0;
            return 1'b0;
        end
        // Indexed mode: index byte, then value byte
        if (cur_tgt == cfg_dot_addr) begin
            if (!idx_seen) begin
                wr_pos   = rx;
                idx_seen = 1'b1;
                return 1'b0;
            end
            idx_seen = 1'b0;
            if (wr_pos < cfg_dots_len) begin
                w.write_target = cfg_dots_tgt;
                w.write_offset = wr_pos;
                w.write_byte   = rx;
                return 1'b1;
            end
            return 1'b0;
        end
        if (cur_tgt == cfg_dots_tgt) begin
            len = cfg_dots_len;
        end else if (cur_tgt == TgtArrayA || cur_tgt == TgtArrayB
                     || cur_tgt == TgtArrayC) begin
            len = arwd_pkg::ArrayLen;
        end else if (cur_tgt <= arwd_pkg::LastFixedTgt && cur_tgt != TgtHoleA
                     && cur_tgt != TgtHoleB) begin
            len = 8'd1;
        end else begin
            len = 8'd0;
        end
        if (len == 8'd0) begin
            return 1'b0;
        end
        // Single register: overwrite in place
        if (len == 8'd1) begin
            w.write_target = cur_tgt;
            w.write_offset = '0;
            w.write_byte   = rx;
            return 1'b1;
        end
        if (wr_pos < len) begin
            w.write_target = cur_tgt;
            w.write_offset = wr_pos;
            w.write_byte   = rx;
            wr_pos = wr_pos + 8'd1;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    // Sender: present queued words, with random idle bursts
    always @(posedge i_clk) begin : drive_words
        arwd_pkg::t_result w;
        t_rx_word          nxt;
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
        end else begin
            if (i_s_tvalid && o_s_tready) begin
                n_words_taken++;
                if (predict_write(i_s_tuser, i_s_tdata, w)) begin
                    due_writes.push_back(w);
                end
            end
            if (!(i_s_tvalid && !o_s_tready)) begin
                if (gap_left > 0) begin
                    gap_left--;
                    i_s_tvalid <= 1'b0;
                end else if (rx_words.size() == 0) begin
                    i_s_tvalid <= 1'b0;
                end else if (!calm && $urandom_range(0, 7) == 0) begin
                    gap_left = $urandom_range(0, 3);
                    i_s_tvalid <= 1'b0;
                end else begin
                    nxt = rx_words.pop_front();
                    i_s_tvalid <= 1'b1;
                    i_s_tuser  <= nxt.addr;
                    i_s_tdata  <= nxt.rx;
                end
            end
        end
    end

    // Receiver: random stall bursts plus one long hold-off to back up the block
    always @(posedge i_clk) begin : drive_ready
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
        end else begin
            if (i_s_tvalid && o_s_tready) begin
                ready_seen++;
            end
            if (!holdoff_done && ready_seen >= HoldoffAt) begin
                holdoff_done = 1'b1;
                holdoff_left = HoldoffCycles;
                i_m_tready <= 1'b0;
            end else if (holdoff_left > 0) begin
                holdoff_left--;
                i_m_tready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                i_m_tready <= 1'b0;
            end else if (!calm && $urandom_range(0, 5) == 0) begin
                stall_left = $urandom_range(0, 3);
                i_m_tready <= 1'b0;
            end else begin
                i_m_tready <= 1'b1;
            end
        end
    end

    // Monitor: compare each write request with the oldest predicted one
    always @(posedge i_clk) begin : check_writes
        arwd_pkg::t_result got;
        arwd_pkg::t_result want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got = o_m_tdata;
            n_writes_seen++;
            if (due_writes.size() == 0) begin
                n_faults++;
                if (n_faults <= MaxShown) begin
                    $display("[%0t] unexpected write: tgt %0d off %0d byte %02h",
                             $realtime, got.write_target, got.write_offset, got.write_byte);
                end
            end else begin
                want = due_writes.pop_front();
                if (got.write_target !== want.write_target
                        || got.write_offset !== want.write_offset
                        || got.write_byte !== want.write_byte) begin
                    n_faults++;
                    if (n_faults <= MaxShown) begin
                        $display({"[%0t] write mismatch: exp tgt %0d off %0d byte %02h,",
                                  " got tgt %0d off %0d byte %02h"},
                                 $realtime, want.write_target, want.write_offset,
                                 want.write_byte, got.write_target, got.write_offset,
                                 got.write_byte);
                    end
                end
            end
        end
    end

    task automatic push_word(input logic addr, input logic [7:0] rx);
        t_rx_word w;
        w.addr = addr;
        w.rx   = rx;
        rx_words.push_back(w);
    endtask

    // Write one register while the streams are idle
    task automatic cfg_write(input logic [arwd_pkg::CfgIdxW-1:0] idx, input logic [7:0] val);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            arwd_pkg::CfgDotIndexAddr: cfg_dot_addr = val;
            arwd_pkg::CfgDotsTarget:   cfg_dots_tgt = val;
            arwd_pkg::CfgDotsLength:   cfg_dots_len = val;
            default: ;
        endcase
    endtask

    task automatic set_config(input logic [7:0] dot_addr, input logic [7:0] dots_tgt,
                              input logic [7:0] dots_len);
        cfg_write(arwd_pkg::CfgDotIndexAddr, dot_addr);
        cfg_write(arwd_pkg::CfgDotsTarget, dots_tgt);
        cfg_write(arwd_pkg::CfgDotsLength, dots_len);
        n_settings++;
    endtask

    // Wait until every word is taken and every write has come, then let the
    // pipeline settle since dropped words leave nothing to wait for
    task automatic drain();
        do @(negedge i_clk);
        while (rx_words.size() != 0 || i_s_tvalid || due_writes.size() != 0);
        repeat (6) @(negedge i_clk);
    endtask

    // Queue addressed bursts with random content, plus some stray words
    task automatic gen_traffic(input int n_data);
        int         n;
        int         k;
        int         pick;
        logic [7:0] tgt;
        logic [7:0] b;
        n = 0;
        while (n < n_data) begin
            if ($urandom_range(0, 9) == 0) begin
                push_word(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
                n++;
            end else begin
                pick = $urandom_range(0, 9);
                case (pick)
                    0, 1:    tgt = cfg_dot_addr;
                    2, 3:    tgt = cfg_dots_tgt;
                    4:       tgt = TgtArrayA;
                    5:       tgt = TgtArrayB;
                    6:       tgt = TgtArrayC;
                    7, 8:    tgt = 8'($urandom_range(0, 37));
                    default: tgt = 8'($urandom_range(0, 255));
                endcase
                push_word(1'b1, tgt);
                k = $urandom_range(1, 12);
                if (tgt == cfg_dots_tgt && cfg_dots_len <= 16) begin
                    k = $urandom_range(1, int'(cfg_dots_len) + 3);
                end
                for (int i = 0; i < k; i++) begin
                    b = 8'($urandom_range(0, 255));
                    // Index bytes: aim at the valid range and its edge
                    if (tgt == cfg_dot_addr && i % 2 == 0 && $urandom_range(0, 1) == 1) begin
                        if (cfg_dots_len == 0) begin
                            b = 8'd0;
                        end else if ($urandom_range(0, 3) == 0) begin
                            b = cfg_dots_len - 8'($urandom_range(0, 1));
                        end else begin
                            b = 8'($urandom_range(0, int'(cfg_dots_len) - 1));
                        end
                    end
                    push_word(1'b0, b);
                end
                n += k;
            end
        end
    endtask

    initial begin : main_seq
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        // Directed part at reset settings
        push_word(1'b1, 8'd0);
        push_word(1'b0, 8'hFF);
        push_word(1'b0, 8'h00);            // single register overwritten in place
        push_word(1'b1, TgtArrayA);
        for (int i = 0; i < 9; i++) begin  // last byte runs past the array end
            push_word(1'b0, 8'(8'h11 * i + (i[0] ? 8'h80 : 8'h00)));
        end
        push_word(1'b1, TgtHoleB);         // indexed mode
        push_word(1'b0, 8'd5);
        push_word(1'b0, 8'hAA);
        push_word(1'b0, 8'd250);           // index beyond dots length
        push_word(1'b0, 8'h55);
        push_word(1'b0, 8'd7);
        push_word(1'b1, TgtHoleB);         // address keeps the index flag, clears position
        push_word(1'b0, 8'h3C);
        push_word(1'b1, TgtHoleA);
        push_word(1'b0, 8'h0F);
        push_word(1'b1, arwd_pkg::LastFixedTgt);
        push_word(1'b0, 8'hF0);
        push_word(1'b1, arwd_pkg::LastFixedTgt + 8'd1);  // unknown target
        push_word(1'b0, 8'h99);
        push_word(1'b1, 8'hFF);
        push_word(1'b0, 8'h01);
        drain();

        gen_traffic(BurstWords);
        drain();
        set_config(8'd0, 8'd255, 8'd0);    // indexed mode on target 0, empty dots array
        gen_traffic(BurstWords);
        drain();
        set_config(8'd255, 8'd0, 8'd255);
        gen_traffic(BurstWords);
        drain();
        set_config(TgtArrayA, TgtArrayB, 8'd1);  // dots array of length one
        gen_traffic(BurstWords);
        drain();
        set_config(8'd40, 8'd40, 8'd5);    // indexed mode wins over the dots target
        gen_traffic(BurstWords);
        drain();
        set_config(TgtArrayC, TgtArrayA, 8'd4);
        gen_traffic(BurstWords);
        drain();
        set_config(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                   8'($urandom_range(0, 255)));
        gen_traffic(BurstWords);
        drain();

        // Closing stretch at reset values with no idling on either side
        calm = 1'b1;
        set_config(arwd_pkg::RstDotIndexAddr, arwd_pkg::RstDotsTarget,
                   arwd_pkg::RstDotsLength);
        gen_traffic(BurstWords);
        drain();

        $display("Covered %0d received words and %0d write requests over %0d settings,",
                 n_words_taken, n_writes_seen, n_settings);
        $display("with one long receiver hold-off and %0d mismatches.", n_faults);
        if (n_faults == 0 && due_writes.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    initial begin : watchdog
        #2000000;
        $display("Timeout: %0d words taken, %0d writes pending", n_words_taken,
                 due_writes.size());
        $display("*** FAILED ***");
        $finish;
    end

endmodule

/* filelist.f */
hdl/arwd_pkg.sv
hdl/arwd_decode.sv
hdl/addressed_register_write_decoder_unit.sv
verif/tb_addressed_register_write_decoder_unit.sv
